// ===== design/kvt_pkg.sv =====
package kvt_pkg;

    // Table geometry.
    localparam int ENTRIES    = 256;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;
    localparam int ADDR_W     = $clog2(ENTRIES);
    localparam int COUNT_W    = $clog2(ENTRIES + 1);

    // Fixed field widths on the stream ports.
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int WORD_W     = 64;
    localparam int ENTRY_CNT_W = 9;
    localparam int S_TDATA_W  = 128;
    localparam int M_TDATA_W  = 80;

    typedef enum logic [FUNC_W-1:0] {
        OP_SET    = 2'd0,
        OP_GET    = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_CAPACITY  = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic load;     // latch a new request and restart the scan
        logic scan_rd;  // read the slot at the scan address
        logic commit;   // apply the update and load the result register
    } t_cmd;

    typedef struct packed {
        logic last_addr; // scan address is at the last slot
        logic out_free;  // result register can take a new result
    } t_stat;

endpackage

// ===== design/key_value_table.sv =====
// Key-value table with a fixed number of slots, searched linearly.
//
// Requests arrive on the s_axis channel: tuser carries the operation
// (set, get or delete), tdata carries the key and the value to store.
// Each request yields exactly one result on the m_axis channel: tuser
// carries the status, tdata the value read and the count of valid entries.
//
// A request is taken only while the block is idle. It then reads one slot
// per cycle from the key and value memories, 256 reads in all, compares the
// last slot in a drain step and applies the update in a write-back step,
// which also loads the result register. No new request is taken until the
// write-back of the current one is done.
//
// The result sits in an output register. A stalled receiver holds it
// there; the block still takes and scans the next request and waits in
// its write-back step until the held result has been taken.
//
// Reset clears all valid bits and the entry count at once, so the table is
// empty and ready for a request as soon as reset is released.
module key_value_table import kvt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [63:0] key, [127:64] write_value
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] func
    input  logic [FUNC_W-1:0]      s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [63:0] read_value, [72:64] entry_count, [79:73] zero
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [STATUS_W-1:0]    m_axis_tuser
);

    t_cmd                   w_cmd;
    t_stat                  w_stat;
    logic [WORD_W-1:0]      w_read_value;
    logic [ENTRY_CNT_W-1:0] w_entry_count;

    // The controller sequences accept, scan, drain and write-back.
    kvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the slot memories, the match logic and the
    // result register.
    kvt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_func        (s_axis_tuser),
        .i_key         (s_axis_tdata[WORD_W-1:0]),
        .i_write_value (s_axis_tdata[2*WORD_W-1:WORD_W]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (m_axis_tuser),
        .o_read_value  (w_read_value),
        .o_entry_count (w_entry_count)
    );

    // Pack the result: value in the low word, count above it, zero padding.
    assign m_axis_tdata = M_TDATA_W'({w_entry_count, w_read_value});

    // Once a request is taken, no second one is taken in the next cycle.
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while a scan was starting");

    // A request that fails returns a zero read value.
    a_value_on_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata[WORD_W-1:0] == '0))
        else $error("read value nonzero on a failed request");

    // A new result is loaded only from the write-back step, never while idle.
    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a completed scan");

endmodule

// ===== design/kvt_ctrl.sv =====
module kvt_ctrl import kvt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last read is compared in this cycle.
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/kvt_datapath.sv =====
module kvt_datapath import kvt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [WORD_W-1:0]   i_key,
    input  logic [WORD_W-1:0]   i_write_value,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [WORD_W-1:0]   o_read_value,
    output logic [ENTRY_CNT_W-1:0] o_entry_count
);

    // Slot storage.
    logic [KEY_BITS-1:0]   mem_key   [ENTRIES];
    logic [VALUE_BITS-1:0] mem_value [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [COUNT_W-1:0]    r_count;

    // Latched request.
    logic [FUNC_W-1:0]     r_func;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_wval;

    // Scan pipeline.
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_rd_pend;
    logic [ADDR_W-1:0]     r_idx_q;
    logic                  r_vld_q;
    logic [KEY_BITS-1:0]   r_key_q;
    logic [VALUE_BITS-1:0] r_val_q;

    // Scan results.
    logic                  r_found;
    logic [ADDR_W-1:0]     r_hit;
    logic [VALUE_BITS-1:0] r_hit_value;
    logic                  r_have_hole;
    logic [ADDR_W-1:0]     r_hole;

    // Result register.
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [WORD_W-1:0]     r_out_rd;
    logic [ENTRY_CNT_W-1:0] r_out_cnt;

    // Update decode.
    t_status               w_status;
    logic [WORD_W-1:0]     w_rd;
    logic                  w_key_we;
    logic                  w_val_we;
    logic [ADDR_W-1:0]     w_wr_addr;
    logic                  w_set_valid;
    logic                  w_clr_valid;
    logic [COUNT_W-1:0]    w_count;

    assign o_stat.last_addr = (r_addr == ADDR_W'(ENTRIES - 1));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_key  <= i_key[KEY_BITS-1:0];
            r_wval <= i_write_value[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_key_we) begin
            mem_key[w_wr_addr] <= r_key;
        end
        if (i_cmd.scan_rd) begin
            r_key_q <= mem_key[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_val_we) begin
            mem_value[w_wr_addr] <= r_wval;
        end
        if (i_cmd.scan_rd) begin
            r_val_q <= mem_value[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_idx_q <= r_addr;
            r_vld_q <= r_valid[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_rd_pend   <= 1'b0;
            r_found     <= 1'b0;
            r_have_hole <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_addr      <= '0;
                r_found     <= 1'b0;
                r_have_hole <= 1'b0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (r_rd_pend) begin
                    if (r_vld_q) begin
                        if (!r_found && (r_key_q == r_key)) begin
                            r_found <= 1'b1;
                        end
                    end else if (!r_have_hole) begin
                        r_have_hole <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            if (r_vld_q && !r_found && (r_key_q == r_key)) begin
                r_hit       <= r_idx_q;
                r_hit_value <= r_val_q;
            end
            if (!r_vld_q && !r_have_hole) begin
                r_hole <= r_idx_q;
            end
        end
    end

    always_comb begin
        w_status    = ST_INVALID;
        w_rd        = '0;
        w_key_we    = 1'b0;
        w_val_we    = 1'b0;
        w_wr_addr   = r_hit;
        w_set_valid = 1'b0;
        w_clr_valid = 1'b0;
        w_count     = r_count;
        case (t_op'(r_func))
            OP_SET: begin
                if (r_key == '0) begin
                    w_status = ST_INVALID;
                end else if (r_found) begin
                    w_val_we = 1'b1;
                    w_status = ST_OK;
                end else if (r_have_hole) begin
                    w_wr_addr   = r_hole;
                    w_key_we    = 1'b1;
                    w_val_we    = 1'b1;
                    w_set_valid = 1'b1;
                    w_count     = r_count + 1'b1;
                    w_status    = ST_OK;
                end else begin
                    w_status = ST_CAPACITY;
                end
            end
            OP_GET: begin
                if (r_found) begin
                    w_rd     = WORD_W'(r_hit_value);
                    w_status = ST_OK;
                end else begin
                    w_status = ST_NOT_FOUND;
                end
            end
            OP_DELETE: begin
                if (r_found) begin
                    w_clr_valid = 1'b1;
                    if (r_count != '0) begin
                        w_count = r_count - 1'b1;
                    end
                    w_status = ST_OK;
                end else begin
                    w_status = ST_NOT_FOUND;
                end
            end
            default: begin
                w_status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            if (w_set_valid) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
            if (w_clr_valid) begin
                r_valid[w_wr_addr] <= 1'b0;
            end
            r_count <= w_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= w_status;
            r_out_rd     <= w_rd;
            r_out_cnt    <= ENTRY_CNT_W'(w_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_read_value  = r_out_rd;
    assign o_entry_count = r_out_cnt;

endmodule
